// ----- sv/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment display package
// Shared item kinds, pattern constants, types and lookup functions.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int DigitCount = 3;
	localparam int ValueWidth = 11;
	localparam int PatWidth   = 8;
	localparam int SegWidth   = 7;
	localparam int MagWidth   = 10;

	localparam logic [1:0] MODE_SHOW = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_SCAN = 2'd2;

	localparam logic [PatWidth-1:0] PAT_MINUS = 8'd2;
	localparam logic [PatWidth-1:0] PAT_BLANK = 8'd0;
	localparam logic [MagWidth-1:0] MAG_LIMIT = 10'd999;

	typedef logic [PatWidth-1:0] pattern_t;

	typedef struct packed {
		logic [1:0]               mode;
		pattern_t [DigitCount-1:0] patterns;
		logic [1:0]               scan_digit;
	} op_t;

	typedef struct packed {
		logic [2:0]          enable_n;
		logic [SegWidth-1:0] segments;
	} drive_t;

	function automatic pattern_t digit_pattern(input logic [3:0] d);
		pattern_t p;
		unique case (d)
			4'd0: p = 8'd252;
			4'd1: p = 8'd160;
			4'd2: p = 8'd62;
			4'd3: p = 8'd186;
			4'd4: p = 8'd226;
			4'd5: p = 8'd218;
			4'd6: p = 8'd222;
			4'd7: p = 8'd176;
			4'd8: p = 8'd254;
			4'd9: p = 8'd250;
			default: p = 8'd252;
		endcase
		return p;
	endfunction

	function automatic logic [SegWidth-1:0] pattern_to_segments(input pattern_t p);
		return {p[1], p[6], p[2], p[3], p[7], p[5], p[4]};
	endfunction

endpackage

// ----- sv/ssd_bcd.sv -----
// ----------------------------------------------------------------------------
// Number to pattern converter
// Splits a signed value into three decimal digits, blanks leading zeros and
// forms the pattern bytes for a show item.
// ----------------------------------------------------------------------------
module ssd_bcd (
	input  logic [ssd_pkg::ValueWidth-1:0]                   value,
	output ssd_pkg::pattern_t [ssd_pkg::DigitCount-1:0]      patterns
);

	logic                            negative;
	logic [ssd_pkg::ValueWidth-1:0]  abs_value;
	logic [ssd_pkg::MagWidth-1:0]    mag;
	logic [15:0]                     hund_prod;
	logic [3:0]                      hund;
	logic [6:0]                      rem;
	logic [14:0]                     tens_prod;
	logic [3:0]                      tens;
	logic [3:0]                      units;

	always_comb begin
		negative  = value[ssd_pkg::ValueWidth-1];
		abs_value = negative ? (~value + 11'd1) : value;
		if (abs_value > {1'b0, ssd_pkg::MAG_LIMIT}) begin
			mag = ssd_pkg::MAG_LIMIT;
		end else begin
			mag = abs_value[ssd_pkg::MagWidth-1:0];
		end
		hund_prod = {6'd0, mag} * 16'd41;
		hund      = hund_prod[15:12];
		rem       = 7'(mag - (10'(hund) * 10'd100));
		tens_prod = {8'd0, rem} * 15'd205;
		tens      = tens_prod[14:11];
		units     = 4'(rem - (7'(tens) * 7'd10));

		patterns[0] = ssd_pkg::digit_pattern(hund);
		patterns[1] = ssd_pkg::digit_pattern(tens);
		patterns[2] = ssd_pkg::digit_pattern(units);
		if (hund == 4'd0) begin
			patterns[0] = ssd_pkg::PAT_BLANK;
			if (tens == 4'd0) begin
				patterns[1] = ssd_pkg::PAT_BLANK;
			end
		end
		if (negative) begin
			patterns[0] = ssd_pkg::PAT_MINUS;
		end
	end

endmodule

// ----- sv/ssd_store.sv -----
// ----------------------------------------------------------------------------
// Pattern store and pin drives
// Holds the three digit patterns and the segment and enable drives, and
// applies one decoded item per transfer.
// ----------------------------------------------------------------------------
module ssd_store (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  ssd_pkg::op_t    op,
	input  logic            oled_mode,
	output ssd_pkg::drive_t drive_next
);

	ssd_pkg::pattern_t [ssd_pkg::DigitCount-1:0] pattern_q;
	ssd_pkg::drive_t                             drive_q;
	logic [1:0]                                  sel;

	always_comb begin
		drive_next = drive_q;
		sel        = op.scan_digit - 2'd1;
		if (op.mode == ssd_pkg::MODE_SCAN && !oled_mode) begin
			if (op.scan_digit == 2'd0) begin
				drive_next.segments = '0;
				drive_next.enable_n = 3'b111;
			end else begin
				drive_next.segments = ssd_pkg::pattern_to_segments(pattern_q[sel]);
				drive_next.enable_n = ~(3'b001 << sel);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q        <= '0;
			drive_q.segments <= '0;
			drive_q.enable_n <= 3'b111;
		end else if (fire) begin
			drive_q <= drive_next;
			if (op.mode == ssd_pkg::MODE_SHOW || op.mode == ssd_pkg::MODE_LOAD) begin
				pattern_q <= op.patterns;
			end
		end
	end

endmodule

// ----- sv/seven_segment_number_display_core.sv -----
// ----------------------------------------------------------------------------
// Seven-segment number display core
// Three-digit multiplexed display driver with integer, raw load and scan items.
// ----------------------------------------------------------------------------
// The core takes one item in every clock cycle unless back-pressure stalls it
// and returns exactly one result per item. Each item passes an input register,
// a register after the decimal conversion, and the result register that feeds
// the output stream. Each pipeline stage stalls only when the stage after it is
// full, so a waiting result does not hold off new items until the pipeline
// fills. The result is the pair of pin drives after the item has been applied.
module seven_segment_number_display_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// value[10:0], raw_left[18:11], raw_middle[26:19], raw_right[34:27],
	// scan_digit[36:35], zero fill above.
	input  logic [39:0] s_axis_tdata,
	// mode[1:0].
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// segments[6:0], digit_enable_n[9:7], zero fill above.
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic                                        valid_s1;
	logic [1:0]                                  mode_s1;
	logic [ssd_pkg::ValueWidth-1:0]              value_s1;
	ssd_pkg::pattern_t [ssd_pkg::DigitCount-1:0] raw_s1;
	logic [1:0]                                  scan_digit_s1;
	ssd_pkg::pattern_t [ssd_pkg::DigitCount-1:0] conv_patterns;
	logic                                        valid_s2;
	ssd_pkg::op_t                                op_s2;
	ssd_pkg::drive_t                             drive_next;
	ssd_pkg::drive_t                             result_q;
	logic                                        out_valid_q;
	logic                                        oled_mode_q;
	logic                                        out_load;
	logic                                        s2_load;
	logic                                        s1_load;
	logic                                        fire;

	assign out_load      = !out_valid_q || m_axis_tready;
	assign s2_load       = !valid_s2 || out_load;
	assign s1_load       = !valid_s1 || s2_load;
	assign s_axis_tready = s1_load;
	assign fire          = valid_s2 && out_load;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oled_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			oled_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && s_axis_tvalid) begin
			mode_s1       <= s_axis_tuser;
			value_s1      <= s_axis_tdata[10:0];
			raw_s1[0]     <= s_axis_tdata[18:11];
			raw_s1[1]     <= s_axis_tdata[26:19];
			raw_s1[2]     <= s_axis_tdata[34:27];
			scan_digit_s1 <= s_axis_tdata[36:35];
		end
	end

	ssd_bcd u_bcd (
		.value    (value_s1),
		.patterns (conv_patterns)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			op_s2.mode       <= mode_s1;
			op_s2.scan_digit <= scan_digit_s1;
			op_s2.patterns   <= (mode_s1 == ssd_pkg::MODE_SHOW) ? conv_patterns : raw_s1;
		end
	end

	ssd_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (op_s2),
		.oled_mode  (oled_mode_q),
		.drive_next (drive_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= drive_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, result_q.enable_n, result_q.segments};

endmodule

// ----- tb/ssd_display_checker.sv -----
// ----------------------------------------------------------------------------
// Seven-segment display result checker
// Watches the item, result and setting channels of the display core. It keeps
// its own copy of the pattern store, the pin drives and the OLED setting,
// predicts the drives after every accepted item and compares each result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module ssd_display_checker
	import ssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          pending,
	output int          errors,
	output int          results
);
	timeunit 1ns;
	timeprecision 1ps;

	pattern_t            glyph_store [DigitCount];
	logic [SegWidth-1:0] seg_now;
	logic [2:0]          enable_now;
	logic                oled_fitted;
	drive_t              expected_drives [$];

	initial errors = 0;

	function automatic pattern_t glyph_of(input int d);
		case (d)
			0: return 8'd252;
			1: return 8'd160;
			2: return 8'd62;
			3: return 8'd186;
			4: return 8'd226;
			5: return 8'd218;
			6: return 8'd222;
			7: return 8'd176;
			8: return 8'd254;
			default: return 8'd250;
		endcase
	endfunction

	function automatic logic [SegWidth-1:0] lit_segments(input pattern_t p);
		logic [SegWidth-1:0] s;
		s[0] = p[4];
		s[1] = p[5];
		s[2] = p[7];
		s[3] = p[3];
		s[4] = p[2];
		s[5] = p[6];
		s[6] = p[1];
		return s;
	endfunction

	function automatic void show_number(input logic [ValueWidth-1:0] v);
		logic [11:0] magnitude;
		int          digits [DigitCount];
		magnitude = v[ValueWidth-1] ? 12'h800 - {1'b0, v} : {1'b0, v};
		if (magnitude > 12'(MAG_LIMIT)) begin
			magnitude = 12'(MAG_LIMIT);
		end
		digits[0] = magnitude / 100;
		digits[1] = (magnitude / 10) % 10;
		digits[2] = magnitude % 10;
		for (int i = 0; i < DigitCount; i++) begin
			glyph_store[i] = glyph_of(digits[i]);
		end
		if (digits[0] == 0) begin
			glyph_store[0] = PAT_BLANK;
			if (digits[1] == 0) begin
				glyph_store[1] = PAT_BLANK;
			end
		end
		if (v[ValueWidth-1]) begin
			glyph_store[0] = PAT_MINUS;
		end
	endfunction

	function automatic void scan_digit(input logic [1:0] d);
		if (oled_fitted) begin
			return;
		end
		if (d == 2'd0) begin
			seg_now = '0;
			enable_now = 3'b111;
		end else begin
			seg_now = lit_segments(glyph_store[d - 1]);
			enable_now = 3'b111 & ~(3'b001 << (d - 1));
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
			$realtime, results, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			for (int i = 0; i < DigitCount; i++) begin
				glyph_store[i] = PAT_BLANK;
			end
			seg_now = '0;
			enable_now = 3'b111;
			oled_fitted = 1'b0;
			expected_drives.delete();
			results = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				oled_fitted = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results++;
				if (expected_drives.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = expected_drives.pop_front();
					if (m_axis_tdata[6:0] !== want.segments) begin
						report_mismatch("segments", m_axis_tdata[6:0], want.segments);
					end
					if (m_axis_tdata[9:7] !== want.enable_n) begin
						report_mismatch("digit_enable_n", m_axis_tdata[9:7], want.enable_n);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					MODE_SHOW: show_number(s_axis_tdata[10:0]);
					MODE_LOAD: begin
						glyph_store[0] = s_axis_tdata[18:11];
						glyph_store[1] = s_axis_tdata[26:19];
						glyph_store[2] = s_axis_tdata[34:27];
					end
					MODE_SCAN: scan_digit(s_axis_tdata[36:35]);
					default: ;
				endcase
				want.segments = seg_now;
				want.enable_n = enable_now;
				expected_drives.push_back(want);
			end
			pending <= expected_drives.size();
		end
	end

endmodule

// ----- tb/seven_segment_number_display_core_tb.sv -----
// ----------------------------------------------------------------------------
// Seven-segment number display core testbench
// Drives integer, raw load, scan and unused items into the core under random
// idling on both streams, switches the OLED setting between phases, and lets
// a separate checker predict and compare every result transfer.
// ----------------------------------------------------------------------------
module seven_segment_number_display_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         CycleLimit  = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = MODE_SHOW;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	int pending;
	int errors;
	int results;

	logic quiet = 1'b0;
	int   stall_left = 0;
	int   cycles = 0;
	int   item_count[4] = '{default: 0};
	int   oled_scans = 0;
	int   setting_writes = 0;
	logic oled_now = 1'b0;

	always #6 clk = ~clk;

	seven_segment_number_display_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	ssd_display_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.errors        (errors),
		.results       (results)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stall bursts until the quiet part of the run.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [10:0] value,
		input logic [7:0] left, input logic [7:0] middle, input logic [7:0] right,
		input logic [1:0] digit);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {3'b000, digit, right, middle, left, value};
		do @(posedge clk); while (!s_axis_tready);
		item_count[kind]++;
		if (kind == MODE_SCAN && oled_now) begin
			oled_scans++;
		end
	endtask

	task automatic show(input logic [10:0] value);
		send_item(MODE_SHOW, value, 8'h00, 8'h00, 8'h00, 2'd0);
	endtask

	task automatic scan(input logic [1:0] digit);
		send_item(MODE_SCAN, 11'h000, 8'h00, 8'h00, 8'h00, digit);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_setting(input logic fitted);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= fitted;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		oled_now = fitted;
		setting_writes++;
	endtask

	function automatic logic [10:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 9))
					0: return 11'h400;
					1: return 11'h7FF;
					2: return 11'h3FF;
					3: return 11'(999);
					4: return 11'(1000);
					5: return -11'sd999;
					6: return -11'sd1000;
					7: return 11'h000;
					8: return 11'(100);
					default: return -11'sd100;
				endcase
			end
			1, 2: return 11'($signed($urandom_range(0, 40)) - 20);
			3: return 11'($urandom_range(0, 99));
			default: return 11'($urandom);
		endcase
	endfunction

	task automatic send_random();
		int          pick;
		logic [1:0]  kind;
		pick = $urandom_range(0, 19);
		if (pick < 6) begin
			kind = MODE_SHOW;
		end else if (pick < 9) begin
			kind = MODE_LOAD;
		end else if (pick < 19) begin
			kind = MODE_SCAN;
		end else begin
			kind = MODE_UNUSED;
		end
		send_item(kind, pick_value(), 8'($urandom), 8'($urandom), 8'($urandom),
			2'($urandom_range(0, 3)));
	endtask

	initial begin
		int phase_items [5] = '{400, 150, 400, 150, 425};
		logic phase_oled [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: blank store after reset, zero, clamping, negatives,
		// leading-zero blanking, raw extremes, the unused kind and OLED holding.
		scan(2'd1);
		show(11'h000);
		scan(2'd3);
		scan(2'd2);
		show(11'(999));
		scan(2'd1);
		show(11'h400);
		scan(2'd1);
		scan(2'd2);
		show(11'h3FF);
		scan(2'd3);
		show(-11'sd5);
		scan(2'd2);
		scan(2'd1);
		show(11'(40));
		scan(2'd2);
		send_item(MODE_LOAD, 11'h000, 8'hFF, 8'h00, 8'hAA, 2'd0);
		scan(2'd1);
		scan(2'd3);
		send_item(MODE_UNUSED, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
		scan(2'd0);
		show(11'(100));
		scan(2'd2);
		write_setting(1'b1);
		scan(2'd1);
		send_item(MODE_LOAD, 11'h000, 8'h55, 8'hAA, 8'h01, 2'd0);
		scan(2'd2);
		scan(2'd0);

		for (int p = 0; p < 5; p++) begin
			write_setting(phase_oled[p]);
			for (int i = 0; i < phase_items[p]; i++) begin
				if (p == 4 && i == 225) begin
					quiet = 1'b1;
				end
				send_random();
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("%0d items: %0d integers, %0d raw loads, %0d scans, %0d unused kind",
			item_count[0] + item_count[1] + item_count[2] + item_count[3],
			item_count[MODE_SHOW], item_count[MODE_LOAD], item_count[MODE_SCAN],
			item_count[MODE_UNUSED]);
		$display("%0d results checked, %0d setting writes, %0d scans with OLED fitted",
			results, setting_writes, oled_scans);
		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/ssd_pkg.sv
sv/ssd_bcd.sv
sv/ssd_store.sv
sv/seven_segment_number_display_core.sv
tb/ssd_display_checker.sv
tb/seven_segment_number_display_core_tb.sv
